FILE: src/tlsd_pkg.sv
// shared widths, codes, state encoding and control structs for the two-level speed dither
// no dependencies; compiled first

package tlsd_pkg;

  localparam int TIME_W     = 16;
  localparam int ARG_W      = 8;
  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 4;
  localparam int LEVEL_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // signed working width for shares and level during an adjust
  localparam int WIDE_W     = 25;
  // dividend width of the renormalization divider
  localparam int DIV_W      = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [TIME_W-1:0]  INTERVAL_RESET = 16'd100;
  localparam logic [TIME_W-1:0]  STEP_RESET     = 16'd10;
  localparam int                 SPEED_MAX      = 14;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP      = 4'd13;
  localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM   = 4'd0;
  localparam logic [CODE_W-1:0]  CODE_REVERSE   = 4'd15;
  localparam logic [CODE_W-1:0]  CODE_NONE      = 4'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_ADJUST  = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPEED   = 2'd0,
    KIND_REVERSE = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_TRAIN    = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_SUM,
    ST_CHK_A,
    ST_DIV_A,
    ST_FIX_A,
    ST_CHK_B,
    ST_DIV_B,
    ST_FIX_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_set;
    logic do_mul;
    logic do_sum;
    logic div_start;
    logic div_sel_b;
    logic div_step;
    logic fix_a;
    logic fix_b;
    logic finish;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  a_over;
    logic  b_over;
    logic  div_last;
    logic  out_free;
  } dp_status_t;

endpackage

FILE: src/tlsd_in_if.sv
// input channel of the speed dither: valid/ready with mode and argument
// depends on tlsd_pkg

interface tlsd_in_if;
  import tlsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [ARG_W-1:0]  arg;

  modport source (output valid, output mode, output arg, input ready);
  modport sink   (input valid, input mode, input arg, output ready);
endinterface

FILE: src/tlsd_out_if.sv
// result channel of the speed dither: valid/ready with kind, speed code and hold time
// depends on tlsd_pkg

interface tlsd_out_if;
  import tlsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CODE_W-1:0]  speed_code;
  logic [TIME_W-1:0]  hold_ticks;

  modport source (output valid, output kind, output speed_code, output hold_ticks, input ready);
  modport sink   (input valid, input kind, input speed_code, input hold_ticks, output ready);
endinterface

FILE: src/tlsd_datapath.sv
// datapath: config registers, dither state, adjust arithmetic, serial divider, output register
// depends on tlsd_pkg; driven by tlsd_ctrl through dp_cmd_t

module tlsd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tlsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tlsd_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [tlsd_pkg::ARG_W-1:0]  in_arg,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tlsd_pkg::KIND_W-1:0]        out_kind,
  output logic [tlsd_pkg::CODE_W-1:0]        out_speed_code,
  output logic [tlsd_pkg::TIME_W-1:0]        out_hold_ticks,
  input  tlsd_pkg::dp_cmd_t                  cmd,
  output tlsd_pkg::dp_status_t               status
);
  import tlsd_pkg::*;

  localparam int PAD_W = WIDE_W - TIME_W;

  logic [MODE_W-1:0]        item_mode;
  logic signed [ARG_W-1:0]  item_arg;
  logic [TIME_W-1:0]        interval;
  logic [TIME_W-1:0]        step;

  logic [LEVEL_W-1:0]       low_level;
  logic [TIME_W-1:0]        low_time;
  logic [TIME_W-1:0]        high_time;
  logic                     phase;

  logic signed [WIDE_W-1:0] delta;
  logic signed [WIDE_W-1:0] a;
  logic signed [WIDE_W-1:0] b;
  logic signed [WIDE_W-1:0] lv;

  logic [DIV_W-1:0]         dvd;
  logic [TIME_W-1:0]        rem;
  logic [DIV_CNT_W-1:0]     cnt;

  logic signed [WIDE_W-1:0] iv_wide;
  logic signed [WIDE_W-1:0] time_max_wide;
  logic signed [WIDE_W-1:0] arg_wide;
  logic signed [WIDE_W-1:0] step_wide;
  logic signed [WIDE_W-1:0] product;
  logic signed [WIDE_W-1:0] low_wide;
  logic signed [WIDE_W-1:0] high_wide;
  logic signed [WIDE_W-1:0] div_src;
  logic signed [WIDE_W-1:0] div_minus;
  logic [TIME_W:0]          trial;
  logic                     trial_ok;
  logic signed [WIDE_W-1:0] share_new;
  logic signed [WIDE_W-1:0] quot_wide;
  logic                     phase_flip;
  logic                     rev_ok;

  function automatic logic [TIME_W-1:0] sat_time(input logic signed [WIDE_W-1:0] v,
                                                 input logic signed [WIDE_W-1:0] vmax);
    if (v[WIDE_W-1]) begin
      return '0;
    end else if (v > vmax) begin
      return '1;
    end else begin
      return v[TIME_W-1:0];
    end
  endfunction

  always_comb begin
    iv_wide       = signed'({{PAD_W{1'b0}}, interval});
    time_max_wide = signed'({{PAD_W{1'b0}}, {TIME_W{1'b1}}});
    arg_wide      = WIDE_W'(item_arg);
    step_wide     = signed'({{PAD_W{1'b0}}, step});
    product       = arg_wide * step_wide;
    low_wide      = signed'({{PAD_W{1'b0}}, low_time});
    high_wide     = signed'({{PAD_W{1'b0}}, high_time});
    div_src       = cmd.div_sel_b ? b : a;
    div_minus     = div_src - WIDE_W'(1);
    // restoring step: shift in the next dividend bit, subtract when it fits
    trial         = {rem, dvd[DIV_W-1]} - {1'b0, interval};
    trial_ok      = !trial[TIME_W];
    // remainder + 1 is the share left inside one interval
    share_new     = signed'({{PAD_W{1'b0}}, rem}) + WIDE_W'(1);
    quot_wide     = signed'({{(WIDE_W-DIV_W){1'b0}}, dvd});
    phase_flip    = ~phase;
    rev_ok        = (low_level == LEVEL_BOTTOM) && (low_time == interval);
  end

  always_comb begin
    status.mode     = mode_t'(item_mode);
    status.a_over   = (interval != '0) && (a > iv_wide);
    status.b_over   = (interval != '0) && (b > iv_wide);
    status.div_last = (cnt == DIV_CNT_W'(1));
    status.out_free = !out_valid || out_ready;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      interval  <= INTERVAL_RESET;
      step      <= STEP_RESET;
      low_level <= LEVEL_BOTTOM;
      low_time  <= INTERVAL_RESET;
      high_time <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_INTERVAL: interval <= cfg_data[TIME_W-1:0];
          CFG_STEP:     step     <= cfg_data[TIME_W-1:0];
          default:      ;
        endcase
      end

      if (cmd.do_set) begin
        if (item_arg >= ARG_W'(SPEED_MAX)) begin
          low_level <= LEVEL_TOP;
          low_time  <= '0;
          high_time <= interval;
        end else if (item_arg[ARG_W-1] || item_arg == '0) begin
          low_level <= LEVEL_BOTTOM;
          low_time  <= interval;
          high_time <= '0;
        end else begin
          low_level <= item_arg[LEVEL_W-1:0];
          low_time  <= interval;
          high_time <= '0;
        end
      end

      if (cmd.finish) begin
        if (lv >= WIDE_W'(SPEED_MAX)) begin
          low_level <= LEVEL_TOP;
          low_time  <= '0;
          high_time <= interval;
        end else if (lv[WIDE_W-1]) begin
          low_level <= LEVEL_BOTTOM;
          low_time  <= interval;
          high_time <= '0;
        end else begin
          low_level <= lv[LEVEL_W-1:0];
          low_time  <= sat_time(a, time_max_wide);
          high_time <= sat_time(b, time_max_wide);
        end
      end

      if (cmd.div_start) begin
        cnt <= DIV_CNT_W'(DIV_W);
      end else if (cmd.div_step) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (status.mode == MODE_TICK) begin
          phase <= phase_flip;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode <= in_mode;
      item_arg  <= in_arg;
    end
    if (cmd.do_mul) begin
      delta <= product;
    end
    if (cmd.do_sum) begin
      a  <= low_wide - delta;
      b  <= high_wide + delta;
      lv <= signed'({{(WIDE_W-LEVEL_W){1'b0}}, low_level});
    end
    if (cmd.div_start) begin
      dvd <= div_minus[DIV_W-1:0];
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DIV_W-2:0], trial_ok};
      rem <= trial_ok ? trial[TIME_W-1:0] : {rem[TIME_W-2:0], dvd[DIV_W-1]};
    end
    if (cmd.fix_a) begin
      a  <= share_new;
      b  <= b + (a - share_new);
      lv <= lv - quot_wide;
    end
    if (cmd.fix_b) begin
      b  <= share_new;
      a  <= a + (b - share_new);
      lv <= lv + quot_wide;
    end
    if (cmd.emit) begin
      if (status.mode == MODE_TICK) begin
        out_kind <= KIND_SPEED;
        if (phase_flip) begin
          out_speed_code <= low_level + LEVEL_W'(1);
          out_hold_ticks <= high_time;
        end else begin
          out_speed_code <= low_level;
          out_hold_ticks <= low_time;
        end
      end else begin
        out_kind       <= rev_ok ? KIND_REVERSE : KIND_REFUSED;
        out_speed_code <= rev_ok ? CODE_REVERSE : CODE_NONE;
        out_hold_ticks <= '0;
      end
    end
  end

endmodule

FILE: src/tlsd_ctrl.sv
// controller: sequences decode, emit, set and the adjust renormalization
// depends on tlsd_pkg; commands tlsd_datapath

module tlsd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlsd_pkg::dp_status_t  status,
  output tlsd_pkg::dp_cmd_t     cmd
);
  import tlsd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.mode)
          MODE_SET: begin
            cmd.do_set = 1'b1;
            state_next = ST_IDLE;
          end
          MODE_ADJUST: begin
            cmd.do_mul = 1'b1;
            state_next = ST_SUM;
          end
          default: state_next = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.do_sum = 1'b1;
        state_next = ST_CHK_A;
      end
      ST_CHK_A: begin
        if (status.a_over) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_A;
        end else begin
          state_next = ST_CHK_B;
        end
      end
      ST_DIV_A: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIX_A;
        end
      end
      ST_FIX_A: begin
        cmd.fix_a  = 1'b1;
        state_next = ST_CHK_B;
      end
      ST_CHK_B: begin
        cmd.div_sel_b = 1'b1;
        if (status.b_over) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_B;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV_B: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIX_B;
        end
      end
      ST_FIX_B: begin
        cmd.fix_b  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/two_level_speed_dither_core.sv
// top level of the two-level speed dither: controller plus datapath
// depends on tlsd_pkg, tlsd_in_if, tlsd_out_if, tlsd_ctrl, tlsd_datapath
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+----------------------------------------
//   in_ch    | in  | valid / ready   | mode[1:0], arg[7:0] signed
//   out_ch   | out | valid / ready   | kind[1:0], speed_code[3:0], hold_ticks[15:0]
//   cfg      | in  | cfg_write       | cfg_index[1:0], cfg_data[15:0]
//
// one item at a time; the input is ready only while the controller idles
// set passes through decode only; tick and reverse through decode and emit, plus any output stall
// adjust: decode, sum, share checks, finish, and a divide and fix per renormalization
//   (at most two); the 24-bit bit-serial divider yields one quotient bit per cycle
// the output register lets an item be accepted while a result waits; that item's
//   result then holds in the emit state until the register frees
// rst is synchronous: shares return to level 0, full interval, config to defaults
// train_id (index 2) is accepted and dropped since it reaches no result field

module two_level_speed_dither_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tlsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  tlsd_in_if.sink                          in_ch,
  tlsd_out_if.source                       out_ch
);
  import tlsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller owns the input handshake
  tlsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath owns state, arithmetic and the output register
  tlsd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_ch.mode),
    .in_arg         (in_ch.arg),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_kind       (out_ch.kind),
    .out_speed_code (out_ch.speed_code),
    .out_hold_ticks (out_ch.hold_ticks),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

FILE: src/tlsd_checker.sv
// port-level checks for the speed dither core, attached by bind
// depends on tlsd_pkg and two_level_speed_dither_core

module tlsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [tlsd_pkg::MODE_W-1:0]    in_mode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tlsd_pkg::KIND_W-1:0]    out_kind,
  input logic [tlsd_pkg::CODE_W-1:0]    out_speed_code,
  input logic [tlsd_pkg::TIME_W-1:0]    out_hold_ticks
);
  import tlsd_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_speed_code) && $stable(out_hold_ticks))
    else $error("result changed while stalled");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // tick or reverse into an empty output shows a result once through decode and emit
  a_emit: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !out_valid && (in_mode == MODE_TICK || in_mode == MODE_REVERSE)
      |-> ##3 out_valid)
    else $error("missing result for tick or reverse");

  // set and adjust produce no result
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !out_valid && (in_mode == MODE_SET || in_mode == MODE_ADJUST)
      |-> ##3 !out_valid)
    else $error("unexpected result for set or adjust");

endmodule

bind two_level_speed_dither_core tlsd_checker u_tlsd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_mode        (in_ch.mode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_speed_code (out_ch.speed_code),
  .out_hold_ticks (out_ch.hold_ticks)
);
